// ===== hw/rtl/qvr_pkg.sv =====
// Shared index types and constants for the quaternion vector rotation pipeline.
package qvr_pkg;

    localparam int NUM_QUAT = 4;
    localparam int NUM_AXIS = 3;

    typedef enum logic [1:0] {
        QUAT_W = 2'd0,
        QUAT_X = 2'd1,
        QUAT_Y = 2'd2,
        QUAT_Z = 2'd3
    } t_quat_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

endpackage

// ===== hw/rtl/qvr_in_if.sv =====
// Input channel of the rotation block: one quaternion and one vector per item.
interface qvr_in_if #(
    parameter int COMP_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] quat_w;
    logic signed [COMP_WIDTH-1:0] quat_x;
    logic signed [COMP_WIDTH-1:0] quat_y;
    logic signed [COMP_WIDTH-1:0] quat_z;
    logic signed [COMP_WIDTH-1:0] vec_x;
    logic signed [COMP_WIDTH-1:0] vec_y;
    logic signed [COMP_WIDTH-1:0] vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// ===== hw/rtl/qvr_out_if.sv =====
// Output channel of the rotation block: one rotated vector and a saturation flag per item.
interface qvr_out_if #(
    parameter int COMP_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] rot_x;
    logic signed [COMP_WIDTH-1:0] rot_y;
    logic signed [COMP_WIDTH-1:0] rot_z;
    logic                         clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, clipped,
        input  ready
    );

    modport sink (
        input  valid, rot_x, rot_y, rot_z, clipped,
        output ready
    );
endinterface

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotation pipeline.
// Throughput is one item per cycle while the output side takes results; each item passes
// through five register stages: vector products, sums for t, split partial products of t and q,
// final sums, then round and saturate.
// A stall holds each full stage whose next stage is held, and empty stages keep taking items behind it.
// Synchronous active-low reset clears the valid bit of each stage; data is not reset.
module quaternion_vector_rotate import qvr_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qvr_in_if.sink   i_in,
    qvr_out_if.source o_out
);
    localparam int TW = 2 * COMP_WIDTH + 2;
    localparam int RW = 3 * COMP_WIDTH + 3;

    logic signed [COMP_WIDTH-1:0] in_q   [NUM_QUAT];
    logic signed [COMP_WIDTH-1:0] in_v   [NUM_AXIS];
    logic signed [TW-1:0]         t_data [NUM_QUAT];
    logic signed [COMP_WIDTH-1:0] t_q    [NUM_QUAT];
    logic signed [RW-1:0]         r_data [NUM_AXIS];
    logic signed [COMP_WIDTH-1:0] rot    [NUM_AXIS];
    logic                         t_valid;
    logic                         t_ready;
    logic                         r_valid;
    logic                         r_ready;

    assign in_q[QUAT_W] = i_in.quat_w;
    assign in_q[QUAT_X] = i_in.quat_x;
    assign in_q[QUAT_Y] = i_in.quat_y;
    assign in_q[QUAT_Z] = i_in.quat_z;
    assign in_v[AXIS_X] = i_in.vec_x;
    assign in_v[AXIS_Y] = i_in.vec_y;
    assign in_v[AXIS_Z] = i_in.vec_z;

    qvr_qv_mult #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_qv_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_q     (in_q),
        .i_v     (in_v),
        .o_valid (t_valid),
        .i_ready (t_ready),
        .o_t     (t_data),
        .o_q     (t_q)
    );

    qvr_tq_mult #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_tq_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (t_valid),
        .o_ready (t_ready),
        .i_t     (t_data),
        .i_q     (t_q),
        .o_valid (r_valid),
        .i_ready (r_ready),
        .o_r     (r_data)
    );

    qvr_round_sat #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_round_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_valid),
        .o_ready   (r_ready),
        .i_r       (r_data),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_rot     (rot),
        .o_clipped (o_out.clipped)
    );

    assign o_out.rot_x = rot[AXIS_X];
    assign o_out.rot_y = rot[AXIS_Y];
    assign o_out.rot_z = rot[AXIS_Z];
endmodule

// ===== hw/rtl/qvr_qv_mult.sv =====
// First Hamilton product t = q * (0, v): a multiply stage and a sum stage.
module qvr_qv_mult import qvr_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COMP_WIDTH-1:0] i_q [NUM_QUAT],
    input  logic signed [COMP_WIDTH-1:0] i_v [NUM_AXIS],
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [2*COMP_WIDTH+1:0] o_t [NUM_QUAT],
    output logic signed [COMP_WIDTH-1:0] o_q [NUM_QUAT]
);
    localparam int PW = 2 * COMP_WIDTH;
    localparam int TW = 2 * COMP_WIDTH + 2;

    logic                         r_v1;
    logic signed [PW-1:0]         r_p  [NUM_AXIS][NUM_QUAT];
    logic signed [PW-1:0]         n_p  [NUM_AXIS][NUM_QUAT];
    logic signed [COMP_WIDTH-1:0] r_q1 [NUM_QUAT];
    logic                         r_v2;
    logic signed [TW-1:0]         r_t  [NUM_QUAT];
    logic signed [TW-1:0]         n_t  [NUM_QUAT];
    logic signed [COMP_WIDTH-1:0] r_q2 [NUM_QUAT];
    logic                         s1_en;
    logic                         s2_en;

    // A stage loads when it is empty or its content moves on in the same cycle.
    assign s2_en   = !r_v2 || i_ready;
    assign s1_en   = !r_v1 || s2_en;
    assign o_ready = s1_en;

    always_comb begin
        for (int a = 0; a < NUM_AXIS; a++) begin
            for (int b = 0; b < NUM_QUAT; b++) begin
                n_p[a][b] = PW'(i_v[a]) * PW'(i_q[b]);
            end
        end
    end

    always_comb begin
        n_t[QUAT_W] = -(TW'(r_p[AXIS_X][QUAT_X]) + TW'(r_p[AXIS_Y][QUAT_Y])
                        + TW'(r_p[AXIS_Z][QUAT_Z]));
        n_t[QUAT_X] = TW'(r_p[AXIS_X][QUAT_W]) + TW'(r_p[AXIS_Z][QUAT_Y])
                      - TW'(r_p[AXIS_Y][QUAT_Z]);
        n_t[QUAT_Y] = TW'(r_p[AXIS_Y][QUAT_W]) - TW'(r_p[AXIS_Z][QUAT_X])
                      + TW'(r_p[AXIS_X][QUAT_Z]);
        n_t[QUAT_Z] = TW'(r_p[AXIS_Z][QUAT_W]) + TW'(r_p[AXIS_Y][QUAT_X])
                      - TW'(r_p[AXIS_X][QUAT_Y]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_en) begin
                r_v1 <= i_valid;
            end
            if (s2_en) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_p  <= n_p;
            r_q1 <= i_q;
        end
        if (s2_en) begin
            r_t  <= n_t;
            r_q2 <= r_q1;
        end
    end

    assign o_valid = r_v2;
    assign o_t     = r_t;
    assign o_q     = r_q2;
endmodule

// ===== hw/rtl/qvr_tq_mult.sv =====
// Second Hamilton product, vector part of t * conj(q), with t split into two halves.
module qvr_tq_mult import qvr_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [2*COMP_WIDTH+1:0] i_t [NUM_QUAT],
    input  logic signed [COMP_WIDTH-1:0]   i_q [NUM_QUAT],
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [3*COMP_WIDTH+2:0] o_r [NUM_AXIS]
);
    localparam int TW = 2 * COMP_WIDTH + 2;
    localparam int LW = 2 * COMP_WIDTH + 1;
    localparam int HW = 2 * COMP_WIDTH + 2;
    localparam int RW = 3 * COMP_WIDTH + 3;

    logic                 r_v3;
    logic signed [LW-1:0] r_pl [NUM_QUAT][NUM_QUAT];
    logic signed [HW-1:0] r_ph [NUM_QUAT][NUM_QUAT];
    logic signed [LW-1:0] n_pl [NUM_QUAT][NUM_QUAT];
    logic signed [HW-1:0] n_ph [NUM_QUAT][NUM_QUAT];
    logic                 r_v4;
    logic signed [RW-1:0] r_r  [NUM_AXIS];
    logic signed [RW-1:0] n_r  [NUM_AXIS];
    logic signed [RW-1:0] pf   [NUM_QUAT][NUM_QUAT];
    logic                 s3_en;
    logic                 s4_en;

    assign s4_en   = !r_v4 || i_ready;
    assign s3_en   = !r_v3 || s4_en;
    assign o_ready = s3_en;

    // The low half of each t component is taken as unsigned, the high half as signed,
    // so each multiplier takes only one part of a t component against a q component.
    always_comb begin
        for (int i = 0; i < NUM_QUAT; i++) begin
            for (int j = 0; j < NUM_QUAT; j++) begin
                if (i != j) begin
                    n_pl[i][j] = LW'($signed({1'b0, i_t[i][COMP_WIDTH-1:0]})) * LW'(i_q[j]);
                    n_ph[i][j] = HW'($signed(i_t[i][TW-1:COMP_WIDTH])) * HW'(i_q[j]);
                end else begin
                    n_pl[i][j] = '0;
                    n_ph[i][j] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_QUAT; i++) begin
            for (int j = 0; j < NUM_QUAT; j++) begin
                pf[i][j] = (RW'(r_ph[i][j]) <<< COMP_WIDTH) + RW'(r_pl[i][j]);
            end
        end
        n_r[AXIS_X] = pf[QUAT_X][QUAT_W] - pf[QUAT_W][QUAT_X]
                      - pf[QUAT_Y][QUAT_Z] + pf[QUAT_Z][QUAT_Y];
        n_r[AXIS_Y] = pf[QUAT_Y][QUAT_W] + pf[QUAT_X][QUAT_Z]
                      - pf[QUAT_W][QUAT_Y] - pf[QUAT_Z][QUAT_X];
        n_r[AXIS_Z] = pf[QUAT_Z][QUAT_W] - pf[QUAT_W][QUAT_Z]
                      - pf[QUAT_X][QUAT_Y] + pf[QUAT_Y][QUAT_X];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s3_en) begin
                r_v3 <= i_valid;
            end
            if (s4_en) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_pl <= n_pl;
            r_ph <= n_ph;
        end
        if (s4_en) begin
            r_r <= n_r;
        end
    end

    assign o_valid = r_v4;
    assign o_r     = r_r;
endmodule

// ===== hw/rtl/qvr_round_sat.sv =====
// Output stage: round to nearest, shift down to Q1 format and saturate each component.
module qvr_round_sat import qvr_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [3*COMP_WIDTH+2:0] i_r [NUM_AXIS],
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [COMP_WIDTH-1:0]   o_rot [NUM_AXIS],
    output logic                           o_clipped
);
    localparam int RW        = 3 * COMP_WIDTH + 3;
    localparam int OUT_SHIFT = 2 * (COMP_WIDTH - 1);
    localparam int SW        = RW - OUT_SHIFT;

    localparam logic signed [RW-1:0] RND_HALF = {{(RW-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
    localparam logic signed [SW-1:0] SAT_MAX  =
        {{(SW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN  =
        {{(SW-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};

    logic                         r_v5;
    logic signed [COMP_WIDTH-1:0] r_rot [NUM_AXIS];
    logic signed [COMP_WIDTH-1:0] n_rot [NUM_AXIS];
    logic                         r_clip;
    logic                         n_clip;
    logic signed [RW-1:0]         shifted [NUM_AXIS];
    logic signed [SW-1:0]         coarse  [NUM_AXIS];
    logic                         s5_en;

    assign s5_en   = !r_v5 || i_ready;
    assign o_ready = s5_en;

    always_comb begin
        n_clip = 1'b0;
        for (int a = 0; a < NUM_AXIS; a++) begin
            shifted[a] = (i_r[a] + RND_HALF) >>> OUT_SHIFT;
            coarse[a]  = $signed(shifted[a][SW-1:0]);
            if (coarse[a] > SAT_MAX) begin
                n_rot[a] = SAT_MAX[COMP_WIDTH-1:0];
                n_clip   = 1'b1;
            end else if (coarse[a] < SAT_MIN) begin
                n_rot[a] = SAT_MIN[COMP_WIDTH-1:0];
                n_clip   = 1'b1;
            end else begin
                n_rot[a] = coarse[a][COMP_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (s5_en) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_en) begin
            r_rot  <= n_rot;
            r_clip <= n_clip;
        end
    end

    assign o_valid   = r_v5;
    assign o_rot     = r_rot;
    assign o_clipped = r_clip;
endmodule

// ===== hw/rtl/qvr_checker.sv =====
// Port-level checker for the rotation pipeline, bound to the top level.
module qvr_checker #(
    parameter int COMP_WIDTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [COMP_WIDTH-1:0] i_rot_x,
    input logic signed [COMP_WIDTH-1:0] i_rot_y,
    input logic signed [COMP_WIDTH-1:0] i_rot_z,
    input logic                         i_clipped
);
    localparam logic signed [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    // Reset empties every stage, so no result can show in the cycle after it.
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // With the output side ready, every stage drains, so the input must be ready.
    assert property (@(posedge i_clk) i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // A stalled result holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rot_x)
            && $stable(i_rot_y) && $stable(i_rot_z) && $stable(i_clipped))
        else $error("stalled result changed");

    // A saturated result has at least one component at a limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |->
            (i_rot_x == SAT_MAX || i_rot_x == SAT_MIN || i_rot_y == SAT_MAX
             || i_rot_y == SAT_MIN || i_rot_z == SAT_MAX || i_rot_z == SAT_MIN))
        else $error("clipped set with no component at a limit");

    // The input ready is known whenever the input is valid, once reset is released.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid |-> !$isunknown(i_in_ready))
        else $error("input ready unknown");
endmodule

bind quaternion_vector_rotate qvr_checker #(
    .COMP_WIDTH(COMP_WIDTH)
) u_qvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rot_x     (o_out.rot_x),
    .i_rot_y     (o_out.rot_y),
    .i_rot_z     (o_out.rot_z),
    .i_clipped   (o_out.clipped)
);
